### rtl/drr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_pkg
// Shared types, codes and the Q0.15 quarter-wave sine generator used to
// build the ramp profile tables at elaboration.
// ----------------------------------------------------------------------------
package drr_pkg;

    // Profile kind carried from the control stage to the output stage
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_DIRECT = 2'd0;
    localparam kind_t KIND_SINE   = 2'd1;
    localparam kind_t KIND_COS    = 2'd2;

    // Signed direction codes
    localparam logic signed [1:0] DIR_STOP = 2'sb00;
    localparam logic signed [1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [1:0] DIR_REV  = 2'sb11;

    // Phase scale: a quarter turn is 2^16
    localparam int unsigned QUARTER = 65536;

    // Fixed-point constants for the sine series
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PIH30   = 64'd1686629713;
    localparam logic [63:0] S_MAX   = 64'd32767;

    // Control stage beat descriptor
    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic signed [1:0] dir;
    } stage_t;

    // Q0.15 sine of a quarter-turn phase (0..65536 maps to 0..pi/2).
    // Only evaluated on constants, to fill the profile tables.
    function automatic logic [14:0] sine_q15(input logic [31:0] phase);
        logic [63:0] p;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        p = (phase > 32'(QUARTER)) ? 64'(QUARTER) : 64'(phase);
        x = (p * PIH30) >> 16;
        x2 = (x * x) >> 30;
        // Horner series of Taylor terms up to x^11
        t = Q30_ONE;
        t = Q30_ONE - (((x2 * t) >> 30) / 110);
        t = Q30_ONE - (((x2 * t) >> 30) / 72);
        t = Q30_ONE - (((x2 * t) >> 30) / 42);
        t = Q30_ONE - (((x2 * t) >> 30) / 20);
        t = Q30_ONE - (((x2 * t) >> 30) / 6);
        s = (x * t) >> 30;
        s = (s + (64'd1 << 14)) >> 15;
        if (s > S_MAX)
        begin
            s = S_MAX;
        end
        return s[14:0];
    endfunction

endpackage

### rtl/drr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_in_if
// Request channel: requested direction and speed magnitude per beat.
// ----------------------------------------------------------------------------
interface drr_in_if;
    logic              valid;
    logic              ready;
    logic signed [1:0] req_dir;
    logic [15:0]       speed_mag;

    modport source (output valid, output req_dir, output speed_mag, input ready);
    modport sink   (input valid, input req_dir, input speed_mag, output ready);
endinterface

### rtl/drr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_out_if
// Command channel: signed speed command per beat.
// ----------------------------------------------------------------------------
interface drr_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] speed_cmd;

    modport source (output valid, output speed_cmd, input ready);
    modport sink   (input valid, input speed_cmd, output ready);
endinterface

### rtl/drr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_ctrl
// Direction tracking and ramp step counter. Classifies each request beat
// and registers the profile kind, step index, sign and speed.
// ----------------------------------------------------------------------------
module drr_ctrl
    import drr_pkg::*;
#(
    parameter int RAMP_STEPS = 100,
    parameter int CNT_W      = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    drr_in_if.sink           req,
    input  logic             take,
    output stage_t           stg,
    output logic [CNT_W-1:0] stg_step,
    output logic [15:0]      stg_speed
);

    logic signed [1:0] settled_reg;
    logic signed [1:0] settled_next;
    logic [CNT_W-1:0]  step_reg;
    logic [CNT_W-1:0]  step_next;
    stage_t            stg_reg;
    stage_t            stg_next;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  k_next;
    logic [15:0]       speed_reg;

    logic              accept;
    logic signed [1:0] dir;
    logic [CNT_W:0]    step_inc;

    assign req.ready = !stg_reg.valid || take;
    assign accept    = req.valid && req.ready;

    // Code 10 is taken as reverse
    assign dir      = (req.req_dir[1]) ? DIR_REV : req.req_dir;
    assign step_inc = {1'b0, step_reg} + {{CNT_W{1'b0}}, 1'b1};

    // Direction and ramp step update
    always_comb
    begin
        settled_next   = settled_reg;
        step_next      = step_reg;
        k_next         = k_reg;
        stg_next.valid = stg_reg.valid;
        stg_next.kind  = stg_reg.kind;
        stg_next.dir   = stg_reg.dir;
        if (req.ready)
        begin
            stg_next.valid = req.valid;
        end
        if (accept)
        begin
            stg_next.kind = KIND_DIRECT;
            stg_next.dir  = dir;
            k_next        = step_reg;
            if (dir != settled_reg)
            begin
                if (step_inc < (CNT_W+1)'(RAMP_STEPS))
                begin
                    step_next     = step_inc[CNT_W-1:0];
                    k_next        = step_inc[CNT_W-1:0];
                    if (settled_reg == DIR_STOP)
                    begin
                        stg_next.kind = KIND_SINE;
                    end
                    else
                    begin
                        stg_next.kind = KIND_COS;
                        stg_next.dir  = settled_reg;
                    end
                end
                else
                begin
                    settled_next = dir;
                    step_next    = '0;
                end
            end
        end
    end

    // Control state and stage descriptor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settled_reg <= DIR_FWD;
            step_reg    <= '0;
            stg_reg     <= '0;
        end
        else
        begin
            settled_reg <= settled_next;
            step_reg    <= step_next;
            stg_reg     <= stg_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (accept)
        begin
            speed_reg <= req.speed_mag;
        end
    end

    assign stg       = stg_reg;
    assign stg_step  = k_reg;
    assign stg_speed = speed_reg;

endmodule

### rtl/drr_profile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_profile
// Profile table lookup, speed scaling and sign, into the output register.
// ----------------------------------------------------------------------------
module drr_profile
    import drr_pkg::*;
#(
    parameter int RAMP_STEPS = 100,
    parameter int CNT_W      = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  stage_t           stg,
    input  logic [CNT_W-1:0] stg_step,
    input  logic [15:0]      stg_speed,
    output logic             take,
    drr_out_if.source        cmd
);

    localparam int DEPTH = 1 << CNT_W;

    // sin_tab: S(k/N quarter turn); cos_tab: bit 15 = negate, 14:0 = |cos|
    logic [14:0] sin_tab [0:DEPTH-1];
    logic [15:0] cos_tab [0:DEPTH-1];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_tab
            localparam logic [31:0] SIN_P = (g * 65536) / RAMP_STEPS;
            localparam logic [31:0] COS_Q = (g * 131072) / RAMP_STEPS;
            localparam logic        COS_N = (COS_Q > 32'(QUARTER));
            localparam logic [31:0] COS_A = COS_N ? (COS_Q - 32'(QUARTER))
                                                  : (32'(QUARTER) - COS_Q);
            if (g < RAMP_STEPS)
            begin : g_live
                assign sin_tab[g] = sine_q15(SIN_P);
                assign cos_tab[g] = {COS_N, sine_q15(COS_A)};
            end
            else
            begin : g_dead
                assign sin_tab[g] = '0;
                assign cos_tab[g] = '0;
            end
        end
    endgenerate

    logic               out_valid_reg;
    logic signed [16:0] cmd_reg;
    logic signed [16:0] cmd_next;
    logic [14:0]        val;
    logic               neg;
    logic [30:0]        prod;
    logic [15:0]        mag;
    logic               flip;

    assign take = !out_valid_reg || cmd.ready;

    // Lookup, scale and sign
    always_comb
    begin
        val  = sin_tab[stg_step];
        neg  = 1'b0;
        if (stg.kind == KIND_COS)
        begin
            val = cos_tab[stg_step][14:0];
            neg = cos_tab[stg_step][15];
        end
        prod = 31'(val) * 31'(stg_speed);
        case (stg.kind)
            KIND_SINE, KIND_COS: mag = prod[30:15];
            default:             mag = stg_speed;
        endcase
        flip = stg.dir[1] ^ neg;
        if (stg.dir == DIR_STOP)
        begin
            cmd_next = '0;
        end
        else if (flip)
        begin
            cmd_next = -$signed({1'b0, mag});
        end
        else
        begin
            cmd_next = $signed({1'b0, mag});
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= stg.valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (take && stg.valid)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd.valid     = out_valid_reg;
    assign cmd.speed_cmd = cmd_reg;

endmodule

### rtl/direction_reversal_ramp_core.sv
`timescale 1ns / 1ps
// A request beat passes the control register, then the output register
// holding the table lookup and 16x15 multiply.
// Throughput: one beat per cycle; ready drops only when both registers
// hold beats and the command side stalls.
// Reset: settled direction forward, ramp step zero, no beats held.
// ----------------------------------------------------------------------------
// direction_reversal_ramp_core
// Sinusoidal velocity ramp across a direction change, top level.
// ----------------------------------------------------------------------------
module direction_reversal_ramp_core
    import drr_pkg::*;
#(
    parameter int RAMP_STEPS = 100
)
(
    input  logic      clk,
    input  logic      rst_n,
    drr_in_if.sink    req,
    drr_out_if.source cmd
);

    localparam int CNT_W = $clog2(RAMP_STEPS);

    stage_t           stg;
    logic [CNT_W-1:0] stg_step;
    logic [15:0]      stg_speed;
    logic             take;

    drr_ctrl #(
        .RAMP_STEPS (RAMP_STEPS),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .take      (take),
        .stg       (stg),
        .stg_step  (stg_step),
        .stg_speed (stg_speed)
    );

    drr_profile #(
        .RAMP_STEPS (RAMP_STEPS),
        .CNT_W      (CNT_W)
    ) u_profile (
        .clk       (clk),
        .rst_n     (rst_n),
        .stg       (stg),
        .stg_step  (stg_step),
        .stg_speed (stg_speed),
        .take      (take),
        .cmd       (cmd)
    );

endmodule
